### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the delay line.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`define ASSERT_NEVER(lbl, ck, rn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)
`define ASSERT_NEVER(lbl, ck, rn, expr)
`endif
`endif

### hdl/fdl_pkg.sv
// Shared constants and types for the feedback delay line.
// No dependencies; used by fdl_mac and feedback_delay_line_core.
`default_nettype none

package fdl_pkg;

  localparam int MAX_DELAY_DEF   = 4096;
  localparam int CHANNELS_DEF    = 2;
  localparam int SAMPLE_BITS_DEF = 16;

  // Unsigned coefficient formats: gain Q0.15, mix Q1.15.
  localparam int GAIN_W   = 15;
  localparam int MIX_W    = 16;
  localparam int Q_FRAC   = 15;
  localparam int Q_ONE    = 32768;
  localparam int RND_HALF = 16384;

  // Result queue depth; must be a power of two.
  localparam int OUT_FIFO_DEPTH = 4;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUFFER_LENGTH = 2'd0,
    REG_DELAY_SAMPLES = 2'd1,
    REG_FEEDBACK_GAIN = 2'd2,
    REG_WET_MIX       = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

### hdl/fdl_ring_ram.sv
// Single-port-write, single-port-read synchronous store for all channel rings.
// Read data is registered; a read and write of the same entry return old data.
`default_nettype none

module fdl_ring_ram #(
  parameter int AW = 13,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hdl/fdl_mac.sv
// Two-stage arithmetic: coefficient products, then rounding and saturation.
// Produces the ring write-back word and the mixed result; uses fdl_pkg.
`default_nettype none

module fdl_mac #(
  parameter int SAMPLE_BITS = 16,
  parameter int AW          = 13
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          s1_valid,
  input  wire logic signed [SAMPLE_BITS-1:0] s1_x,
  input  wire logic        [AW-1:0]          s1_addr,
  input  wire logic signed [SAMPLE_BITS-1:0] delayed,
  input  wire logic [fdl_pkg::GAIN_W-1:0]    gain,
  input  wire logic [fdl_pkg::MIX_W-1:0]     mix,
  input  wire logic [fdl_pkg::MIX_W-1:0]     dry,
  output logic                               wr_en,
  output logic        [AW-1:0]               wr_addr,
  output logic signed [SAMPLE_BITS-1:0]      wr_data,
  output logic                               res_valid,
  output logic        [SAMPLE_BITS-1:0]      res_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int PF_W  = SB + 16;
  localparam int PM_W  = SB + 17;
  localparam int SUM_W = SB + 18;

  localparam logic signed [SUM_W-1:0] RND  = SUM_W'(fdl_pkg::RND_HALF);
  localparam logic signed [SUM_W-1:0] SMAX = SUM_W'((longint'(1) <<< (SB - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SMIN = ~SMAX;

  function automatic logic [SB-1:0] sat_f(input logic signed [SUM_W-1:0] v);
    logic [SB-1:0] r;
    if (v > SMAX) begin
      r = SMAX[SB-1:0];
    end else if (v < SMIN) begin
      r = SMIN[SB-1:0];
    end else begin
      r = v[SB-1:0];
    end
    return r;
  endfunction

  logic signed [PF_W-1:0] p_fb;
  logic signed [PM_W-1:0] p_dry;
  logic signed [PM_W-1:0] p_wet;

  assign p_fb  = $signed({1'b0, gain}) * delayed;
  assign p_dry = $signed({1'b0, dry}) * s1_x;
  assign p_wet = $signed({1'b0, mix}) * delayed;

  logic                   s2_valid_r;
  logic signed [SB-1:0]   s2_x_r;
  logic        [AW-1:0]   s2_addr_r;
  logic signed [PF_W-1:0] p_fb_r;
  logic signed [PM_W-1:0] p_dry_r;
  logic signed [PM_W-1:0] p_wet_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_x_r    <= s1_x;
    s2_addr_r <= s1_addr;
    p_fb_r    <= p_fb;
    p_dry_r   <= p_dry;
    p_wet_r   <= p_wet;
  end

  // Rounding adds one half and floors, so halves go towards plus infinity.
  logic signed [SUM_W-1:0] fb_sum;
  logic signed [SUM_W-1:0] fb_q;
  logic signed [SUM_W-1:0] w_sum;
  logic signed [SUM_W-1:0] mix_sum;
  logic signed [SUM_W-1:0] mix_q;

  assign fb_sum  = SUM_W'(p_fb_r) + RND;
  assign fb_q    = fb_sum >>> fdl_pkg::Q_FRAC;
  assign w_sum   = fb_q + SUM_W'(s2_x_r);
  assign mix_sum = SUM_W'(p_dry_r) + SUM_W'(p_wet_r) + RND;
  assign mix_q   = mix_sum >>> fdl_pkg::Q_FRAC;

  assign wr_en     = s2_valid_r;
  assign wr_addr   = s2_addr_r;
  assign wr_data   = $signed(sat_f(w_sum));
  assign res_valid = s2_valid_r;
  assign res_data  = sat_f(mix_q);

endmodule

`default_nettype wire

### hdl/fdl_out_fifo.sv
// Small result queue that decouples the arithmetic pipeline from the receiver.
// Reports its fill level so the input side can hold back words it cannot place.
`default_nettype none

module fdl_out_fifo #(
  parameter int W     = 16,
  parameter int DEPTH = 4,
  localparam int PW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [W-1:0]  push_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic      [W-1:0]  out_data,
  output logic      [CW-1:0] count
);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wptr_r;
  logic [PW-1:0] rptr_r;
  logic [CW-1:0] count_r;
  logic          pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = mem_r[rptr_r];
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + PW'(1);
      end
      priority if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end else begin
        count_r <= count_r;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/feedback_delay_line_core.sv
// Multi-channel feedback delay (comb filter) with dry/wet mix; top level.
// Depends on fdl_pkg, fdl_ring_ram, fdl_mac, fdl_out_fifo and assert_macros.svh.
//
// Input words (in_sample_in, in_channel_index) are taken when in_valid is high
// and in_stall low; each produces exactly one out_sample_out word, in order.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must write them only while idle (not enforced).
// Accepted words pass the stage 1 registers, stage 2 in fdl_mac and the result queue to out_valid.
// Throughput is one word per cycle while the receiver keeps up and no sweep runs.
// The exception is an item that reads the ring entry the previous item is still
// computing (a delay of one on that channel, or a length of one): the feedback
// path through the multiplier and saturation then holds it back, signalled by in_stall.
// After reset every ring entry is swept to zero, one entry per cycle, all
// 2**(channel bits + position bits) of them (8192 with the defaults); in_stall stays
// high meanwhile, and configuration writes are taken as usual.
// When the receiver stalls, a four-word result queue absorbs words already in the
// pipeline and in_stall rises once the queue and pipeline together hold four words.
`default_nettype none

`include "assert_macros.svh"

module feedback_delay_line_core #(
  parameter int MAX_DELAY   = fdl_pkg::MAX_DELAY_DEF,
  parameter int CHANNELS    = fdl_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF,
  localparam int POS_W      = $clog2(MAX_DELAY),
  localparam int LEN_W      = POS_W + 1,
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int CFG_W      = (LEN_W > fdl_pkg::MIX_W) ? LEN_W : fdl_pkg::MIX_W
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]   in_sample_in,
  input  wire logic        [CH_W-1:0]          in_channel_index,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [SAMPLE_BITS-1:0]        out_sample_out,
  input  wire logic                            cfg_we,
  input  wire logic [fdl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]                cfg_wdata
);

  localparam int SB    = SAMPLE_BITS;
  localparam int AW    = CH_W + POS_W;
  localparam int DEPTH = fdl_pkg::OUT_FIFO_DEPTH;
  localparam int FC_W  = $clog2(DEPTH + 1);
  localparam int MW    = fdl_pkg::MIX_W;
  localparam logic [MW-1:0] Q_ONE = MW'(fdl_pkg::Q_ONE);

  // Configuration registers; length and mix are clamped as they are written.
  logic [LEN_W-1:0]           len_r;
  logic [POS_W-1:0]           dly_r;
  logic [fdl_pkg::GAIN_W-1:0] gain_r;
  logic [MW-1:0]              mix_r;
  logic [MW-1:0]              dry_r;

  logic [LEN_W-1:0] cfg_len_v;
  logic [LEN_W-1:0] cfg_len_c;
  logic [MW-1:0]    cfg_mix_v;
  logic [MW-1:0]    cfg_mix_c;

  assign cfg_len_v = cfg_wdata[LEN_W-1:0];
  assign cfg_mix_v = cfg_wdata[MW-1:0];

  always_comb begin
    priority if (cfg_len_v == '0) begin
      cfg_len_c = LEN_W'(1);
    end else if (cfg_len_v > LEN_W'(MAX_DELAY)) begin
      cfg_len_c = LEN_W'(MAX_DELAY);
    end else begin
      cfg_len_c = cfg_len_v;
    end
  end

  assign cfg_mix_c = (cfg_mix_v > Q_ONE) ? Q_ONE : cfg_mix_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= LEN_W'(MAX_DELAY);
      dly_r  <= '0;
      gain_r <= '0;
      mix_r  <= '0;
      dry_r  <= Q_ONE;
    end else if (cfg_we) begin
      unique case (fdl_pkg::cfg_reg_t'(cfg_index))
        fdl_pkg::REG_BUFFER_LENGTH: len_r  <= cfg_len_c;
        fdl_pkg::REG_DELAY_SAMPLES: dly_r  <= cfg_wdata[POS_W-1:0];
        fdl_pkg::REG_FEEDBACK_GAIN: gain_r <= cfg_wdata[fdl_pkg::GAIN_W-1:0];
        fdl_pkg::REG_WET_MIX: begin
          mix_r <= cfg_mix_c;
          dry_r <= Q_ONE - cfg_mix_c;
        end
      endcase
    end
  end

  // Post-reset sweep that zeroes every ring entry.
  logic          clearing_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (&clr_addr_r) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Address generation for the incoming word.
  logic [POS_W-1:0] wpos_r [CHANNELS];
  logic [CH_W-1:0]  ch_c;
  logic [POS_W-1:0] wp_raw;
  logic [POS_W-1:0] wp;
  logic [POS_W-1:0] dly_e;
  logic [POS_W-1:0] rd_pos;
  logic [LEN_W-1:0] wp_inc;
  logic [POS_W-1:0] wp_nxt;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr_s0;

  assign ch_c = ({1'b0, in_channel_index} >= (CH_W + 1)'(CHANNELS)) ?
                CH_W'(CHANNELS - 1) : in_channel_index;
  assign wp_raw = wpos_r[ch_c];
  // A position left beyond a shortened ring restarts at the beginning.
  assign wp     = ({1'b0, wp_raw} >= len_r) ? '0 : wp_raw;
  assign dly_e  = ({1'b0, dly_r} >= len_r) ? POS_W'(len_r - LEN_W'(1)) : dly_r;
  assign rd_pos = (wp >= dly_e) ? (wp - dly_e) :
                  POS_W'({1'b0, wp} + len_r - {1'b0, dly_e});
  assign wp_inc = {1'b0, wp} + LEN_W'(1);
  assign wp_nxt = (wp_inc == len_r) ? '0 : wp_inc[POS_W-1:0];
  assign rd_addr    = {ch_c, rd_pos};
  assign wr_addr_s0 = {ch_c, wp};

  // Stage 1 registers and pipeline hazard handling.
  logic                 s1_valid_r;
  logic signed [SB-1:0] s1_x_r;
  logic [AW-1:0]        s1_addr_r;
  logic                 s1_byp_r;
  logic signed [SB-1:0] s1_byp_data_r;

  logic                 mac_we;
  logic [AW-1:0]        mac_waddr;
  logic signed [SB-1:0] mac_wdata;
  logic                 mac_res_valid;
  logic [SB-1:0]        mac_res_data;
  logic [FC_W-1:0]      fifo_count;

  logic                 hazard;
  logic                 byp_hit;
  logic [FC_W:0]        in_flight;
  logic                 credit_full;
  logic                 in_accept;

  // The word in stage 1 writes its entry only after this read would happen.
  assign hazard  = s1_valid_r && (rd_addr == s1_addr_r);
  // The word in stage 2 writes at the same edge as this read; take its data.
  assign byp_hit = mac_we && (mac_waddr == rd_addr);

  assign in_flight   = (FC_W + 1)'(fifo_count) + (FC_W + 1)'(s1_valid_r) +
                       (FC_W + 1)'(mac_res_valid);
  assign credit_full = (in_flight >= (FC_W + 1)'(DEPTH));
  assign in_stall    = clearing_r || credit_full || hazard;
  assign in_accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        wpos_r[i] <= '0;
      end
    end else begin
      s1_valid_r <= in_accept;
      if (in_accept) begin
        wpos_r[ch_c] <= wp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_x_r        <= in_sample_in;
      s1_addr_r     <= wr_addr_s0;
      s1_byp_r      <= byp_hit;
      s1_byp_data_r <= mac_wdata;
    end
  end

  // Ring store.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SB-1:0] ram_wdata;
  logic [SB-1:0] ram_rdata;
  logic signed [SB-1:0] delayed;

  assign ram_we    = clearing_r || mac_we;
  assign ram_waddr = clearing_r ? clr_addr_r : mac_waddr;
  assign ram_wdata = clearing_r ? '0 : mac_wdata;
  assign delayed   = s1_byp_r ? s1_byp_data_r : $signed(ram_rdata);

  fdl_ring_ram #(
    .AW(AW),
    .DW(SB)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  fdl_mac #(
    .SAMPLE_BITS(SB),
    .AW         (AW)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid_r),
    .s1_x     (s1_x_r),
    .s1_addr  (s1_addr_r),
    .delayed  (delayed),
    .gain     (gain_r),
    .mix      (mix_r),
    .dry      (dry_r),
    .wr_en    (mac_we),
    .wr_addr  (mac_waddr),
    .wr_data  (mac_wdata),
    .res_valid(mac_res_valid),
    .res_data (mac_res_data)
  );

  logic [SB-1:0] fifo_data;

  fdl_out_fifo #(
    .W    (SB),
    .DEPTH(DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (mac_res_valid),
    .push_data(mac_res_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (fifo_data),
    .count    (fifo_count)
  );

  assign out_sample_out = $signed(fifo_data);

  `ASSERT_NEVER(a_no_dp_write_in_clear, clk, rst_n, clearing_r && mac_we)
  `ASSERT_IMPLY(a_fifo_room_on_push, clk, rst_n, mac_res_valid,
                fifo_count < FC_W'(DEPTH))
  `ASSERT_IMPLY(a_s1_pos_in_ring, clk, rst_n, s1_valid_r,
                {1'b0, s1_addr_r[POS_W-1:0]} < len_r)
  `ASSERT_NEXT(a_interlock_drains_s1, clk, rst_n, in_valid && hazard, !s1_valid_r)

endmodule

`default_nettype wire
